[src/lfu_pkg.sv]
// Shared types and constants for the LFU key/value store with LRU tie break.
package lfu_pkg;

    // Store size and use-count width.
    localparam int CAPACITY    = 16;
    localparam int COUNT_WIDTH = 16;

    // Field widths.
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 5;
    localparam int IN_W   = 72;
    localparam int OUT_W  = 40;

    // Derived widths: slot index, recency rank, occupancy count.
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam int USED_W = $clog2(CAPACITY + 1);
    localparam int CAPW   = (CFG_W > USED_W) ? CFG_W : USED_W;

    localparam logic [CFG_W-1:0]       CAP_RESET = CFG_W'(16);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [VAL_W-1:0]       VAL_MISS  = '1;
    localparam logic [VAL_W-1:0]       VAL_PUT   = '0;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESULT
    } t_state;

    // One memory word: everything held for a slot except its valid bit.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
        logic [COUNT_WIDTH-1:0]  count;
        logic [RANK_W-1:0]       rank;
    } t_entry;

    // What the lookup sweep found.
    typedef struct packed {
        logic                    hit;
        logic [IDX_W-1:0]        hit_idx;
        logic signed [VAL_W-1:0] hit_value;
        logic [COUNT_WIDTH-1:0]  hit_count;
        logic [RANK_W-1:0]       hit_rank;
        logic                    vic_found;
        logic [IDX_W-1:0]        vic_idx;
        logic [COUNT_WIDTH-1:0]  vic_count;
        logic [RANK_W-1:0]       vic_rank;
        logic                    free_found;
        logic [IDX_W-1:0]        free_idx;
    } t_scan;

endpackage

[src/lfu_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module lfu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

[src/lfu_scan.sv]
// Lookup sweep: finds the matching key, the eviction victim and a free slot.
module lfu_scan import lfu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_clear,
    input  logic                    i_chk_vld,
    input  logic [IDX_W-1:0]        i_chk_idx,
    input  logic                    i_chk_valid_bit,
    input  t_entry                  i_entry,
    input  logic signed [KEY_W-1:0] i_key,
    output t_scan                   o_scan
);

    t_scan r_scan;
    t_scan n_scan;
    logic  en;
    logic  better;

    // Fold one slot into the running results.
    always_comb begin
        n_scan = r_scan;
        en     = i_chk_vld && i_chk_valid_bit;
        better = !r_scan.vic_found
                 || (i_entry.count < r_scan.vic_count)
                 || ((i_entry.count == r_scan.vic_count) && (i_entry.rank < r_scan.vic_rank));
        if (i_clear) begin
            n_scan = '0;
        end else begin
            if (en && !r_scan.hit && (i_entry.key == i_key)) begin
                n_scan.hit       = 1'b1;
                n_scan.hit_idx   = i_chk_idx;
                n_scan.hit_value = i_entry.value;
                n_scan.hit_count = i_entry.count;
                n_scan.hit_rank  = i_entry.rank;
            end
            if (en && better) begin
                n_scan.vic_found = 1'b1;
                n_scan.vic_idx   = i_chk_idx;
                n_scan.vic_count = i_entry.count;
                n_scan.vic_rank  = i_entry.rank;
            end
            if (i_chk_vld && !i_chk_valid_bit && !r_scan.free_found) begin
                n_scan.free_found = 1'b1;
                n_scan.free_idx   = i_chk_idx;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

[src/lfu_cache_with_lru_tiebreak_top.sv]
// Top level of the LFU key/value store with least-recently-used tie break.
// Each request is a get or a put and gives exactly one result. All slot
// contents (key, value, use count, recency rank) live in one dual-port RAM
// with one read and one write per cycle, and valid bits sit in flip-flops.
// A request first sweeps every slot through the read port to find the key,
// the victim and a free slot. A get miss, a put while capacity is zero, and
// a put into a free slot then finish. A hit or a put that evicts runs a
// second read-modify-write sweep that closes the recency ranks and writes
// the slot. The next request is taken while a finished result still waits
// on the output.
module lfu_cache_with_lru_tiebreak_top import lfu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: capacity_in_use.
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Request stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // command[0], key[32:1], value[64:33], zeros
    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // hit[0], read_value[32:1], zeros
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]        r_cap;
    logic [USED_W-1:0]       r_used;
    logic [CAPACITY-1:0]     r_valid;

    // Latched request.
    t_cmd                    r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_val;

    // Sweep counter and read pipeline.
    logic [USED_W-1:0]       r_cnt;
    logic                    r_chk_vld;
    logic [IDX_W-1:0]        r_chk_idx;

    // Update sweep target.
    logic [IDX_W-1:0]        r_tgt;
    logic [RANK_W-1:0]       r_thr;
    t_entry                  r_new;

    // Pending result and output register.
    logic                    r_res_hit;
    logic [VAL_W-1:0]        r_res_val;
    logic                    r_out_vld;
    logic                    r_out_hit;
    logic [VAL_W-1:0]        r_out_val;

    // Control from the state machine.
    logic accept, issue, sweep_end, load_out;
    logic dec_update, dec_insert;

    t_scan  scan;
    t_entry rd_entry;
    t_entry new_entry;
    t_entry dec_entry;
    logic   ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry ram_wdata;

    logic [CAPW-1:0]   cap_eff;
    logic [CAPW-1:0]   cap_ext;
    logic [CAPW-1:0]   used_ext;
    logic              full;
    logic              cap_zero;
    logic [USED_W-1:0] used_m1;
    logic [COUNT_WIDTH-1:0] hit_count_inc;
    logic              upd_en, is_tgt, rank_above;

    // Effective capacity, clamped to the store size.
    always_comb begin
        cap_ext  = CAPW'(r_cap);
        cap_eff  = (cap_ext > CAPW'(CAPACITY)) ? CAPW'(CAPACITY) : cap_ext;
        used_ext = CAPW'(r_used);
        full     = used_ext >= cap_eff;
        cap_zero = cap_eff == '0;
        used_m1  = r_used - USED_W'(1);
        hit_count_inc = (scan.hit_count == COUNT_MAX) ? scan.hit_count
                                                      : scan.hit_count + COUNT_WIDTH'(1);
    end

    // State machine: next state and control strobes.
    always_comb begin
        n_state    = r_state;
        accept     = 1'b0;
        issue      = 1'b0;
        sweep_end  = 1'b0;
        load_out   = 1'b0;
        dec_update = 1'b0;
        dec_insert = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                accept = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN, S_UPDATE: begin
                issue     = r_cnt != USED_W'(CAPACITY);
                sweep_end = r_cnt == USED_W'(CAPACITY);
                if (sweep_end) begin
                    n_state = (r_state == S_SCAN) ? S_DECIDE : S_RESULT;
                end
            end
            S_DECIDE: begin
                n_state = S_RESULT;
                if (r_cmd == CMD_GET) begin
                    dec_update = scan.hit;
                end else if (!cap_zero) begin
                    dec_update = scan.hit || full;
                    dec_insert = !scan.hit && !full;
                end
                if (dec_update) begin
                    n_state = S_UPDATE;
                end
            end
            S_RESULT: begin
                load_out = !r_out_vld || m_axis_tready;
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Entry memory.
    lfu_ram #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // Lookup sweep.
    lfu_scan u_scan (
        .i_clk           (i_clk),
        .i_clear         (accept),
        .i_chk_vld       (r_chk_vld && (r_state == S_SCAN)),
        .i_chk_idx       (r_chk_idx),
        .i_chk_valid_bit (r_valid[r_chk_idx]),
        .i_entry         (rd_entry),
        .i_key           (r_key),
        .o_scan          (scan)
    );

    // Target word for a hit or an eviction: the new rank is the top one.
    always_comb begin
        dec_entry.key   = r_key;
        dec_entry.rank  = used_m1[RANK_W-1:0];
        if (scan.hit) begin
            dec_entry.value = (r_cmd == CMD_PUT) ? r_val : scan.hit_value;
            dec_entry.count = hit_count_inc;
        end else begin
            dec_entry.value = r_val;
            dec_entry.count = COUNT_WIDTH'(1);
        end
        // Insert into a free slot: the rank is the current occupancy.
        new_entry.key   = r_key;
        new_entry.value = r_val;
        new_entry.count = COUNT_WIDTH'(1);
        new_entry.rank  = r_used[RANK_W-1:0];
    end

    // Write port: free-slot insert at decide, or the rank-closing sweep.
    always_comb begin
        upd_en     = (r_state == S_UPDATE) && r_chk_vld && r_valid[r_chk_idx];
        is_tgt     = r_chk_idx == r_tgt;
        rank_above = rd_entry.rank > r_thr;
        ram_we     = 1'b0;
        ram_waddr  = r_chk_idx;
        ram_wdata  = rd_entry;
        if (dec_insert) begin
            ram_we    = 1'b1;
            ram_waddr = scan.free_idx;
            ram_wdata = new_entry;
        end else if (upd_en && is_tgt) begin
            ram_we    = 1'b1;
            ram_wdata = r_new;
        end else if (upd_en && rank_above) begin
            ram_we         = 1'b1;
            ram_wdata.rank = rd_entry.rank - RANK_W'(1);
        end
    end

    // Control registers: configuration, occupancy, valid bits, sweep, output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_used    <= '0;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (dec_insert) begin
                r_used                  <= r_used + USED_W'(1);
                r_valid[scan.free_idx]  <= 1'b1;
            end
            if (accept || (r_state == S_DECIDE)) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + USED_W'(1);
            end
            r_chk_vld <= issue;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_cnt[IDX_W-1:0];
        if (accept) begin
            r_cmd <= t_cmd'(s_axis_tdata[0]);
            r_key <= s_axis_tdata[KEY_W:1];
            r_val <= s_axis_tdata[KEY_W+VAL_W:KEY_W+1];
        end
        if (r_state == S_DECIDE) begin
            r_res_hit <= scan.hit;
            if (r_cmd == CMD_PUT) begin
                r_res_val <= VAL_PUT;
            end else if (scan.hit) begin
                r_res_val <= scan.hit_value;
            end else begin
                r_res_val <= VAL_MISS;
            end
            r_tgt <= scan.hit ? scan.hit_idx : scan.vic_idx;
            r_thr <= scan.hit ? scan.hit_rank : scan.vic_rank;
            r_new <= dec_entry;
        end
        if (load_out) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_W - VAL_W - 1)'(0), r_out_val, r_out_hit};

endmodule
